// ===== sv/atfe_pkg.sv =====
// Package for the API transmit frame encoder.
// Holds the transaction structs, command queue types and frame constants.
// No dependencies.
`default_nettype none

package atfe_pkg;

  // Frame kind codes carried by a start transaction
  localparam logic [1:0] OP_UNICAST   = 2'd0;
  localparam logic [1:0] OP_BROADCAST = 2'd1;
  localparam logic [1:0] OP_NODE_DISC = 2'd2;

  // Frame constants
  localparam logic [7:0]  START_DELIM  = 8'h7E;
  localparam logic [7:0]  TYPE_TX_REQ  = 8'h10;
  localparam logic [7:0]  TYPE_AT_CMD  = 8'h08;
  localparam logic [7:0]  BYTE_FF      = 8'hFF;
  localparam logic [7:0]  BYTE_FE      = 8'hFE;
  localparam logic [7:0]  BYTE_01      = 8'h01;
  localparam logic [7:0]  BYTE_00      = 8'h00;
  localparam logic [7:0]  ND_LEN_L     = 8'h04;
  localparam logic [7:0]  AT_CHAR_N    = 8'h4E;
  localparam logic [7:0]  AT_CHAR_D    = 8'h44;
  localparam logic [7:0]  SUM_INIT     = 8'hFF;
  localparam logic [7:0]  BCAST_ID     = 8'h01;
  localparam logic [15:0] MAX_PAYLOAD  = 16'd65521;
  localparam logic [15:0] LEN_OVERHEAD = 16'd14;

  // Header lengths in bytes, without payload and checksum
  localparam logic [4:0] TX_HDR_LEN = 5'd17;
  localparam logic [4:0] ND_HDR_LEN = 5'd7;

  // Command queue geometry
  localparam int CQ_DEPTH = 4;
  localparam int CQ_AW    = $clog2(CQ_DEPTH);

  typedef struct packed {
    logic [1:0]  opcode;
    logic        start_frame;
    logic [15:0] payload_len;
    logic [63:0] dest_addr;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       run_last;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_UNICAST,
    CMD_BROADCAST,
    CMD_NODE_DISC,
    CMD_DATA
  } cmd_kind_t;

  // One command from the front to the serializer
  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] frame_len;
    logic [7:0]  frame_id;
    logic [63:0] dest_addr;
    logic [7:0]  data_byte;
    logic        has_data;
    logic        has_cks;
  } cmd_t;

endpackage

`default_nettype wire

// ===== sv/atfe_front.sv =====
// Front end: accepts input transactions, classifies them and tracks
// the frame counter and the payload bytes still expected. Uses atfe_pkg.
`default_nettype none

module atfe_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_accept,
  input  wire atfe_pkg::in_item_t in_item,
  output logic                 cmd_valid,
  output atfe_pkg::cmd_t       cmd
);

  logic [7:0]  frame_counter_r, frame_counter_nxt;
  logic [15:0] bytes_rem_r, bytes_rem_nxt;
  logic [7:0]  next_id;
  logic [15:0] plen_sat;

  // Next frame ID skips zero
  assign next_id  = (frame_counter_r == 8'hFF) ? 8'h01 : frame_counter_r + 8'h01;
  assign plen_sat = (in_item.payload_len > atfe_pkg::MAX_PAYLOAD) ?
                    atfe_pkg::MAX_PAYLOAD : in_item.payload_len;

  // Classify the transaction into a serializer command
  always_comb begin
    frame_counter_nxt = frame_counter_r;
    bytes_rem_nxt     = bytes_rem_r;
    cmd_valid         = 1'b0;
    cmd.kind          = atfe_pkg::CMD_DATA;
    cmd.frame_len     = plen_sat + atfe_pkg::LEN_OVERHEAD;
    cmd.frame_id      = next_id;
    cmd.dest_addr     = in_item.dest_addr;
    cmd.data_byte     = in_item.data_byte;
    cmd.has_data      = 1'b0;
    cmd.has_cks       = 1'b0;
    if (in_item.start_frame) begin
      case (in_item.opcode)
        atfe_pkg::OP_UNICAST, atfe_pkg::OP_BROADCAST: begin
          cmd_valid     = 1'b1;
          cmd.has_data  = (plen_sat != 16'd0);
          cmd.has_cks   = (plen_sat <= 16'd1);
          bytes_rem_nxt = (plen_sat != 16'd0) ? plen_sat - 16'd1 : 16'd0;
          if (in_item.opcode == atfe_pkg::OP_UNICAST) begin
            cmd.kind          = atfe_pkg::CMD_UNICAST;
            frame_counter_nxt = next_id;
          end else begin
            cmd.kind     = atfe_pkg::CMD_BROADCAST;
            cmd.frame_id = atfe_pkg::BCAST_ID;
          end
        end
        atfe_pkg::OP_NODE_DISC: begin
          cmd_valid         = 1'b1;
          cmd.kind          = atfe_pkg::CMD_NODE_DISC;
          cmd.has_cks       = 1'b1;
          bytes_rem_nxt     = 16'd0;
          frame_counter_nxt = next_id;
        end
        default: begin
          // unused opcode: no frame, no state change
        end
      endcase
    end else if (bytes_rem_r != 16'd0) begin
      cmd_valid     = 1'b1;
      cmd.has_data  = 1'b1;
      cmd.has_cks   = (bytes_rem_r == 16'd1);
      bytes_rem_nxt = bytes_rem_r - 16'd1;
    end
    if (!in_accept) begin
      cmd_valid         = 1'b0;
      frame_counter_nxt = frame_counter_r;
      bytes_rem_nxt     = bytes_rem_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_counter_r <= 8'h00;
      bytes_rem_r     <= 16'd0;
    end else begin
      frame_counter_r <= frame_counter_nxt;
      bytes_rem_r     <= bytes_rem_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/atfe_cmdq.sv =====
// Short command queue between the front end and the serializer.
// Register array read at the head pointer. Uses atfe_pkg.
`default_nettype none

module atfe_cmdq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_en,
  input  wire atfe_pkg::cmd_t wr_cmd,
  output logic                full,
  output logic                head_valid,
  output atfe_pkg::cmd_t      head_cmd,
  input  wire logic           rd_en
);

  atfe_pkg::cmd_t mem [atfe_pkg::CQ_DEPTH];
  logic [atfe_pkg::CQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [atfe_pkg::CQ_AW:0]   count_r, count_nxt;

  assign full       = (count_r == (atfe_pkg::CQ_AW+1)'(atfe_pkg::CQ_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (wr_en && !(rd_en && head_valid)) count_nxt = count_r + 1'b1;
    else if (!wr_en && rd_en && head_valid) count_nxt = count_r - 1'b1;
  end

  // Storage
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr_r] <= wr_cmd;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (rd_en && head_valid) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/atfe_back.sv =====
// Serializer: steps through each command one byte per unstalled cycle,
// keeps the running checksum and holds the output register. Uses atfe_pkg.
`default_nettype none

module atfe_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cmd_valid,
  input  wire atfe_pkg::cmd_t    cmd,
  output logic                   cmd_done,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output atfe_pkg::out_item_t    out_item
);

  logic [4:0] idx_r, idx_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic       out_valid_r;
  atfe_pkg::out_item_t out_item_r;

  logic       advance;
  logic [4:0] hdr_len, last_idx, dsel_full;
  logic [2:0] dsel;
  logic [7:0] hdr_byte, cur_byte, sum_base;
  logic       is_hdr, is_data, summed, is_last, is_start;

  assign advance   = cmd_valid && (!out_valid_r || out_pop);
  assign is_start  = (cmd.kind != atfe_pkg::CMD_DATA);
  assign dsel_full = 5'd12 - idx_r;
  assign dsel      = dsel_full[2:0];

  // Header length and position decode
  always_comb begin
    case (cmd.kind)
      atfe_pkg::CMD_UNICAST, atfe_pkg::CMD_BROADCAST: hdr_len = atfe_pkg::TX_HDR_LEN;
      atfe_pkg::CMD_NODE_DISC:                        hdr_len = atfe_pkg::ND_HDR_LEN;
      default:                                        hdr_len = 5'd0;
    endcase
    last_idx = hdr_len + {4'd0, cmd.has_data} + {4'd0, cmd.has_cks} - 5'd1;
    is_hdr   = (idx_r < hdr_len);
    is_data  = !is_hdr && cmd.has_data && (idx_r == hdr_len);
    is_last  = (idx_r == last_idx);
  end

  // Header byte at the current position
  always_comb begin
    hdr_byte = atfe_pkg::BYTE_00;
    case (idx_r)
      5'd0: hdr_byte = atfe_pkg::START_DELIM;
      5'd1: hdr_byte = (cmd.kind == atfe_pkg::CMD_NODE_DISC) ? atfe_pkg::BYTE_00
                                                              : cmd.frame_len[15:8];
      5'd2: hdr_byte = (cmd.kind == atfe_pkg::CMD_NODE_DISC) ? atfe_pkg::ND_LEN_L
                                                              : cmd.frame_len[7:0];
      5'd3: hdr_byte = (cmd.kind == atfe_pkg::CMD_NODE_DISC) ? atfe_pkg::TYPE_AT_CMD
                                                              : atfe_pkg::TYPE_TX_REQ;
      5'd4: hdr_byte = cmd.frame_id;
      5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12: begin
        if (cmd.kind == atfe_pkg::CMD_NODE_DISC)
          hdr_byte = (idx_r == 5'd5) ? atfe_pkg::AT_CHAR_N : atfe_pkg::AT_CHAR_D;
        else if (cmd.kind == atfe_pkg::CMD_UNICAST)
          hdr_byte = cmd.dest_addr[{dsel, 3'b000} +: 8];
        else
          hdr_byte = (idx_r >= 5'd11) ? atfe_pkg::BYTE_FF : atfe_pkg::BYTE_00;
      end
      5'd13: hdr_byte = atfe_pkg::BYTE_FF;
      5'd14: hdr_byte = atfe_pkg::BYTE_FE;
      5'd15: hdr_byte = (cmd.kind == atfe_pkg::CMD_UNICAST) ? atfe_pkg::BYTE_00
                                                             : atfe_pkg::BYTE_01;
      5'd16: hdr_byte = (cmd.kind == atfe_pkg::CMD_UNICAST) ? atfe_pkg::BYTE_01
                                                             : atfe_pkg::BYTE_00;
      default: hdr_byte = atfe_pkg::BYTE_00;
    endcase
  end

  // Byte select and checksum update; a new frame restarts the sum
  always_comb begin
    sum_base = (is_start && idx_r == 5'd0) ? atfe_pkg::SUM_INIT : sum_r;
    if (is_hdr)       cur_byte = hdr_byte;
    else if (is_data) cur_byte = cmd.data_byte;
    else              cur_byte = sum_base;
    summed  = (is_hdr && idx_r >= 5'd3) || is_data;
    sum_nxt = summed ? sum_base - cur_byte : sum_base;
    idx_nxt = is_last ? 5'd0 : idx_r + 5'd1;
  end

  assign cmd_done  = advance && is_last;
  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;

  // Output register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r.out_byte  <= cur_byte;
      out_item_r.frame_end <= !is_hdr && !is_data;
      out_item_r.run_last  <= is_last;
    end
  end

  // Sequencer and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 5'd0;
      sum_r       <= atfe_pkg::SUM_INIT;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        idx_r <= idx_nxt;
        sum_r <= sum_nxt;
      end
      if (advance)      out_valid_r <= 1'b1;
      else if (out_pop) out_valid_r <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== sv/api_tx_frame_encoder_top.sv =====
// API transmit frame encoder: one input transaction opens a frame (header
// plus optional first payload byte) or adds a payload byte; results are the
// serialized frame bytes with a closing checksum. The front end takes one
// input transaction per cycle, unless the queue is full, into a four-entry
// command queue; the serializer emits one byte per cycle while the output
// is popped, and a start transaction yields 8 to 19 output bytes and a
// payload byte 1 to 2. The output byte rate of one per cycle sets the
// sustained throughput. Depends on atfe_pkg, atfe_front, atfe_cmdq and atfe_back.
`default_nettype none

module api_tx_frame_encoder_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  output logic                     in_full,
  input  wire atfe_pkg::in_item_t  in_item,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output atfe_pkg::out_item_t      out_item
);

  logic           in_accept;
  logic           fe_cmd_valid;
  atfe_pkg::cmd_t fe_cmd;
  logic           q_head_valid;
  atfe_pkg::cmd_t q_head_cmd;
  logic           be_cmd_done;

  assign in_accept = in_push && !in_full;

  atfe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_item   (in_item),
    .cmd_valid (fe_cmd_valid),
    .cmd       (fe_cmd)
  );

  atfe_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (fe_cmd_valid),
    .wr_cmd     (fe_cmd),
    .full       (in_full),
    .head_valid (q_head_valid),
    .head_cmd   (q_head_cmd),
    .rd_en      (be_cmd_done)
  );

  atfe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_head_valid),
    .cmd       (q_head_cmd),
    .cmd_done  (be_cmd_done),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
